[rtl/twdfr_pkg.sv]
// ----------------------------------------------------------------------------
// twdfr_pkg
// Shared types and constants for the telemetry word deframer: receive
// phases, register map, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package twdfr_pkg;

    // Default number of axis angle words in a telemetry frame
    localparam int AXIS_COUNT_DEF = 6;

    // Mask bits that must all be set for a valid position
    localparam logic [31:0] POS_MASK = 32'h0000_0007;

    // Register map (word index = paddr[3:2])
    localparam int          ADDR_W       = 4;
    localparam logic [1:0]  REG_TEL_BEGIN = 2'd0;
    localparam logic [1:0]  REG_TEL_END   = 2'd1;
    localparam logic [1:0]  REG_CAL_BEGIN = 2'd2;
    localparam logic [1:0]  REG_CAL_END   = 2'd3;

    // Receive and delivery phases
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MASK,
        PH_ANGLES,
        PH_X,
        PH_Y,
        PH_Z,
        PH_END,
        PH_CSEQ,
        PH_COK,
        PH_CX,
        PH_CY,
        PH_CZ,
        PH_CEND,
        PH_EMIT_T,
        PH_EMIT_C
    } t_phase;

    // Frame codes held in the configuration registers
    typedef struct packed {
        logic [31:0] tel_begin;
        logic [31:0] tel_end;
        logic [31:0] cal_begin;
        logic [31:0] cal_end;
    } t_cfg;

    // Controller to datapath commands
    typedef struct packed {
        logic ang_clr;
        logic ld_mask;
        logic ld_angle;
        logic ld_tx;
        logic ld_ty;
        logic ld_tz;
        logic ld_cseq;
        logic ld_cok;
        logic ld_cx;
        logic ld_cy;
        logic ld_cz;
        logic emit_clr;
        logic emit_inc;
        logic emit_cal;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic tel_begin_hit;
        logic cal_begin_hit;
        logic tel_end_hit;
        logic cal_end_hit;
        logic ang_last;
        logic emit_last;
    } t_dp_sts;

endpackage

[rtl/twdfr_ctrl.sv]
// ----------------------------------------------------------------------------
// twdfr_ctrl
// Frame controller: tracks the receive phase, issues store loads to the
// datapath and sequences the delivery of results on the output channel.
// ----------------------------------------------------------------------------
module twdfr_ctrl
    import twdfr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_is_message,
    input  logic    i_ready,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output logic    o_valid,
    output t_dp_cmd o_cmd
);

    t_phase r_phase;
    t_phase n_phase;
    logic   take;

    // Phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // Accept words only while receiving; hold input during delivery
    assign o_ready = (r_phase != PH_EMIT_T) && (r_phase != PH_EMIT_C);
    assign o_valid = !o_ready;
    assign take    = i_valid && o_ready && i_is_message;

    // Next phase and datapath commands
    always_comb begin
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.emit_cal = (r_phase == PH_EMIT_C);
        if (take && i_sts.tel_begin_hit) begin
            // restart a telemetry frame
            o_cmd.ang_clr = 1'b1;
            n_phase       = PH_MASK;
        end else if (take && i_sts.cal_begin_hit) begin
            n_phase = PH_CSEQ;
        end else begin
            case (r_phase)
                PH_MASK: begin
                    if (take) begin
                        o_cmd.ld_mask = 1'b1;
                        n_phase       = PH_ANGLES;
                    end
                end
                PH_ANGLES: begin
                    if (take) begin
                        o_cmd.ld_angle = 1'b1;
                        if (i_sts.ang_last) begin
                            n_phase = PH_X;
                        end
                    end
                end
                PH_X: begin
                    if (take) begin
                        o_cmd.ld_tx = 1'b1;
                        n_phase     = PH_Y;
                    end
                end
                PH_Y: begin
                    if (take) begin
                        o_cmd.ld_ty = 1'b1;
                        n_phase     = PH_Z;
                    end
                end
                PH_Z: begin
                    if (take) begin
                        o_cmd.ld_tz = 1'b1;
                        n_phase     = PH_END;
                    end
                end
                PH_END: begin
                    if (take) begin
                        // deliver on a matching end word, drop otherwise
                        o_cmd.emit_clr = 1'b1;
                        n_phase = i_sts.tel_end_hit ? PH_EMIT_T : PH_IDLE;
                    end
                end
                PH_CSEQ: begin
                    if (take) begin
                        o_cmd.ld_cseq = 1'b1;
                        n_phase       = PH_COK;
                    end
                end
                PH_COK: begin
                    if (take) begin
                        o_cmd.ld_cok = 1'b1;
                        n_phase      = PH_CX;
                    end
                end
                PH_CX: begin
                    if (take) begin
                        o_cmd.ld_cx = 1'b1;
                        n_phase     = PH_CY;
                    end
                end
                PH_CY: begin
                    if (take) begin
                        o_cmd.ld_cy = 1'b1;
                        n_phase     = PH_CZ;
                    end
                end
                PH_CZ: begin
                    if (take) begin
                        o_cmd.ld_cz = 1'b1;
                        n_phase     = PH_CEND;
                    end
                end
                PH_CEND: begin
                    if (take) begin
                        n_phase = i_sts.cal_end_hit ? PH_EMIT_C : PH_IDLE;
                    end
                end
                PH_EMIT_T: begin
                    // advance one axis per delivered word
                    if (i_ready) begin
                        o_cmd.emit_inc = 1'b1;
                        if (i_sts.emit_last) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_EMIT_C: begin
                    if (i_ready) begin
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/twdfr_dp.sv]
// ----------------------------------------------------------------------------
// twdfr_dp
// Deframer datapath: code comparators, frame stores, angle write counter,
// delivery axis counter and the result word mux.
// ----------------------------------------------------------------------------
module twdfr_dp
    import twdfr_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic [31:0]        i_word,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    output logic               o_frame_kind,
    output logic [31:0]        o_telem_mask,
    output logic               o_position_valid,
    output logic [3:0]         o_axis_index,
    output logic signed [31:0] o_axis_angle,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [31:0]        o_calib_sequence,
    output logic               o_calib_success,
    output logic               o_last
);

    localparam int CNT_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(AXIS_COUNT - 1);

    logic [CNT_W-1:0] r_ang_cnt;
    logic [CNT_W-1:0] r_emit_idx;
    logic [31:0]      r_mask;
    logic [31:0]      r_angle [AXIS_COUNT];
    logic [31:0]      r_tx, r_ty, r_tz;
    logic [31:0]      r_cseq;
    logic             r_cok;
    logic [31:0]      r_cx, r_cy, r_cz;

    // Compare the incoming word against the frame codes
    assign o_sts.tel_begin_hit = (i_word == i_cfg.tel_begin);
    assign o_sts.cal_begin_hit = (i_word == i_cfg.cal_begin);
    assign o_sts.tel_end_hit   = (i_word == i_cfg.tel_end);
    assign o_sts.cal_end_hit   = (i_word == i_cfg.cal_end);
    assign o_sts.ang_last      = (r_ang_cnt == CNT_LAST);
    assign o_sts.emit_last     = (r_emit_idx == CNT_LAST);

    // Angle write counter and delivery axis counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_cnt  <= '0;
            r_emit_idx <= '0;
        end else begin
            if (i_cmd.ang_clr) begin
                r_ang_cnt <= '0;
            end else if (i_cmd.ld_angle) begin
                r_ang_cnt <= r_ang_cnt + 1'b1;
            end
            if (i_cmd.emit_clr) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit_inc) begin
                r_emit_idx <= r_emit_idx + 1'b1;
            end
        end
    end

    // Frame stores, loaded one word at a time
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_mask)  r_mask <= i_word;
        if (i_cmd.ld_angle) r_angle[r_ang_cnt] <= i_word;
        if (i_cmd.ld_tx)    r_tx   <= i_word;
        if (i_cmd.ld_ty)    r_ty   <= i_word;
        if (i_cmd.ld_tz)    r_tz   <= i_word;
        if (i_cmd.ld_cseq)  r_cseq <= i_word;
        if (i_cmd.ld_cok)   r_cok  <= (i_word != '0);
        if (i_cmd.ld_cx)    r_cx   <= i_word;
        if (i_cmd.ld_cy)    r_cy   <= i_word;
        if (i_cmd.ld_cz)    r_cz   <= i_word;
    end

    // Result word: telemetry fields or calibration fields, unused ones zero
    always_comb begin
        o_frame_kind = i_cmd.emit_cal;
        if (i_cmd.emit_cal) begin
            o_telem_mask     = '0;
            o_position_valid = 1'b0;
            o_axis_index     = '0;
            o_axis_angle     = '0;
            o_pos_x          = r_cx;
            o_pos_y          = r_cy;
            o_pos_z          = r_cz;
            o_calib_sequence = r_cseq;
            o_calib_success  = r_cok;
            o_last           = 1'b1;
        end else begin
            o_telem_mask     = r_mask;
            o_position_valid = ((r_mask & POS_MASK) == POS_MASK);
            o_axis_index     = 4'(r_emit_idx);
            o_axis_angle     = r_angle[r_emit_idx];
            o_pos_x          = r_tx;
            o_pos_y          = r_ty;
            o_pos_z          = r_tz;
            o_calib_sequence = '0;
            o_calib_success  = 1'b0;
            o_last           = o_sts.emit_last;
        end
    end

endmodule

[rtl/arm_telemetry_word_deframer.sv]
// ----------------------------------------------------------------------------
// arm_telemetry_word_deframer
// Deframes mailbox words into telemetry results (one per axis) and
// calibration results, with the four frame codes set over an APB port.
//
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_is_message, i_word
//  output    out        o_valid / i_ready    frame fields, o_last
//  config    in         psel/penable/pready  paddr, pwdata, prdata
//
// One word is taken per cycle while a frame is being received.
// A delivered telemetry frame then holds the input for AXIS_COUNT result
// words, one per output handshake; a calibration frame holds it for one.
// The result mux reads the frame stores directly, indexed by the axis counter.
// Reset is synchronous, active low: it returns to idle and zeroes the codes.
// A stalled output holds the result and the input stays not ready.
// ----------------------------------------------------------------------------
module arm_telemetry_word_deframer
    import twdfr_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // word input
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_is_message,
    input  logic [31:0]        i_word,
    // result output
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_frame_kind,
    output logic [31:0]        o_telem_mask,
    output logic               o_position_valid,
    output logic [3:0]         o_axis_index,
    output logic signed [31:0] o_axis_angle,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [31:0] o_pos_z,
    output logic [31:0]        o_calib_sequence,
    output logic               o_calib_success,
    output logic               o_last
);

    t_cfg    r_cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_wr;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_TEL_BEGIN: r_cfg.tel_begin <= pwdata;
                REG_TEL_END:   r_cfg.tel_end   <= pwdata;
                REG_CAL_BEGIN: r_cfg.cal_begin <= pwdata;
                REG_CAL_END:   r_cfg.cal_end   <= pwdata;
                default:       r_cfg           <= r_cfg;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            REG_TEL_BEGIN: prdata = r_cfg.tel_begin;
            REG_TEL_END:   prdata = r_cfg.tel_end;
            REG_CAL_BEGIN: prdata = r_cfg.cal_begin;
            REG_CAL_END:   prdata = r_cfg.cal_end;
            default:       prdata = '0;
        endcase
    end

    twdfr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_is_message (i_is_message),
        .i_ready      (i_ready),
        .i_sts        (sts),
        .o_ready      (o_ready),
        .o_valid      (o_valid),
        .o_cmd        (cmd)
    );

    twdfr_dp #(
        .AXIS_COUNT (AXIS_COUNT)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_word           (i_word),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_frame_kind     (o_frame_kind),
        .o_telem_mask     (o_telem_mask),
        .o_position_valid (o_position_valid),
        .o_axis_index     (o_axis_index),
        .o_axis_angle     (o_axis_angle),
        .o_pos_x          (o_pos_x),
        .o_pos_y          (o_pos_y),
        .o_pos_z          (o_pos_z),
        .o_calib_sequence (o_calib_sequence),
        .o_calib_success  (o_calib_success),
        .o_last           (o_last)
    );

    // Receiving and delivering never overlap
    a_rx_tx_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_ready))
        else $error("input ready while a result is pending");

    // The final result of a frame returns the block to receiving
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (o_ready && !o_valid))
        else $error("result pending after final word delivered");

    // A calibration result is always a single, final word
    a_cal_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_kind) |-> o_last)
        else $error("calibration result not marked last");

    // No result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_valid)
        else $error("result pending after reset");

endmodule

[sim/arm_telemetry_word_deframer_tb.sv]
// ----------------------------------------------------------------------------
// arm_telemetry_word_deframer_tb
// Self-checking bench for the telemetry word deframer. Telemetry and
// calibration frames, clean and damaged, are fed through the word channel
// under several sets of frame codes. Each accepted word runs through a local
// deframer model that queues the expected results, and every result word is
// checked field by field against the oldest one. Both channels idle at
// random, and the output is held off long enough to back up the input.
// ----------------------------------------------------------------------------
module arm_telemetry_word_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twdfr_pkg::*;

    localparam int AXES          = AXIS_COUNT_DEF;
    localparam int SETTLE_CYCLES = 2 * AXES + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;

    // Damage applied to a generated frame
    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_END,
        FLAW_CUT,
        FLAW_EVENTS
    } t_frame_flaw;

    typedef struct {
        logic        frame_kind;
        logic [31:0] telem_mask;
        logic        position_valid;
        logic [3:0]  axis_index;
        logic [31:0] axis_angle;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] calib_sequence;
        logic        calib_success;
        logic        last;
    } t_deframe_result;

    // DUT ports; the inputs are all known from time zero
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_is_message = 1'b0;
    logic [31:0]        i_word = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic               o_frame_kind;
    logic [31:0]        o_telem_mask;
    logic               o_position_valid;
    logic [3:0]         o_axis_index;
    logic signed [31:0] o_axis_angle;
    logic signed [31:0] o_pos_x;
    logic signed [31:0] o_pos_y;
    logic signed [31:0] o_pos_z;
    logic [31:0]        o_calib_sequence;
    logic               o_calib_success;
    logic               o_last;

    // Frame codes as last written over the register port
    logic [31:0] code_tel_begin = '0;
    logic [31:0] code_tel_end   = '0;
    logic [31:0] code_cal_begin = '0;
    logic [31:0] code_cal_end   = '0;

    // Deframer model state
    t_phase      rx_ph = PH_IDLE;
    logic [31:0] mask_q;
    logic [31:0] angle_q [AXES];
    int          angle_cnt = 0;
    logic [31:0] tel_pos [3];
    logic [31:0] cal_seq_q;
    logic        cal_ok_q;
    logic [31:0] cal_pos [3];

    t_deframe_result pending_results [$];
    logic [31:0]     frame_words [$];

    int errors       = 0;
    int stall_cycles = 0;
    int words_sent   = 0;
    int burst_left   = 0;
    bit sender_steady = 1'b0;
    bit hold_req      = 1'b0;

    arm_telemetry_word_deframer #(
        .AXIS_COUNT(AXES)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_is_message    (i_is_message),
        .i_word          (i_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_frame_kind    (o_frame_kind),
        .o_telem_mask    (o_telem_mask),
        .o_position_valid(o_position_valid),
        .o_axis_index    (o_axis_index),
        .o_axis_angle    (o_axis_angle),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_pos_z         (o_pos_z),
        .o_calib_sequence(o_calib_sequence),
        .o_calib_success (o_calib_success),
        .o_last          (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Advance the deframer model by one accepted word and queue its results
    function automatic void deframe_word(input logic msg, input logic [31:0] w);
        t_deframe_result r;
        if (!msg) return;
        // begin codes restart from any phase, telemetry first
        if (w == code_tel_begin) begin
            angle_cnt = 0;
            rx_ph = PH_MASK;
            return;
        end
        if (w == code_cal_begin) begin
            rx_ph = PH_CSEQ;
            return;
        end
        case (rx_ph)
            PH_MASK: begin
                mask_q = w;
                rx_ph = PH_ANGLES;
            end
            PH_ANGLES: begin
                angle_q[angle_cnt % AXES] = w;
                angle_cnt++;
                if (angle_cnt >= AXES) rx_ph = PH_X;
            end
            PH_X: begin
                tel_pos[0] = w;
                rx_ph = PH_Y;
            end
            PH_Y: begin
                tel_pos[1] = w;
                rx_ph = PH_Z;
            end
            PH_Z: begin
                tel_pos[2] = w;
                rx_ph = PH_END;
            end
            PH_END: begin
                if (w == code_tel_end) begin
                    for (int i = 0; i < AXES; i++) begin
                        r.frame_kind     = 1'b0;
                        r.telem_mask     = mask_q;
                        r.position_valid = ((mask_q & POS_MASK) == POS_MASK);
                        r.axis_index     = 4'(i);
                        r.axis_angle     = angle_q[i];
                        r.pos_x          = tel_pos[0];
                        r.pos_y          = tel_pos[1];
                        r.pos_z          = tel_pos[2];
                        r.calib_sequence = '0;
                        r.calib_success  = 1'b0;
                        r.last           = (i == AXES - 1);
                        pending_results.push_back(r);
                    end
                end
                rx_ph = PH_IDLE;
            end
            PH_CSEQ: begin
                cal_seq_q = w;
                rx_ph = PH_COK;
            end
            PH_COK: begin
                cal_ok_q = (w != '0);
                rx_ph = PH_CX;
            end
            PH_CX: begin
                cal_pos[0] = w;
                rx_ph = PH_CY;
            end
            PH_CY: begin
                cal_pos[1] = w;
                rx_ph = PH_CZ;
            end
            PH_CZ: begin
                cal_pos[2] = w;
                rx_ph = PH_CEND;
            end
            PH_CEND: begin
                if (w == code_cal_end) begin
                    r.frame_kind     = 1'b1;
                    r.telem_mask     = '0;
                    r.position_valid = 1'b0;
                    r.axis_index     = '0;
                    r.axis_angle     = '0;
                    r.pos_x          = cal_pos[0];
                    r.pos_y          = cal_pos[1];
                    r.pos_z          = cal_pos[2];
                    r.calib_sequence = cal_seq_q;
                    r.calib_success  = cal_ok_q;
                    r.last           = 1'b1;
                    pending_results.push_back(r);
                end
                rx_ph = PH_IDLE;
            end
            default: rx_ph = PH_IDLE;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endfunction

    // Compare one result word against the oldest expectation
    function automatic void check_result();
        t_deframe_result e;
        if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: result word expected none actual axis %0d kind %0d",
                     $time, o_axis_index, o_frame_kind);
            return;
        end
        e = pending_results.pop_front();
        check_field("frame_kind", 32'(e.frame_kind), 32'(o_frame_kind));
        check_field("telem_mask", e.telem_mask, o_telem_mask);
        check_field("position_valid", 32'(e.position_valid), 32'(o_position_valid));
        check_field("axis_index", 32'(e.axis_index), 32'(o_axis_index));
        check_field("axis_angle", e.axis_angle, o_axis_angle);
        check_field("pos_x", e.pos_x, o_pos_x);
        check_field("pos_y", e.pos_y, o_pos_y);
        check_field("pos_z", e.pos_z, o_pos_z);
        check_field("calib_sequence", e.calib_sequence, o_calib_sequence);
        check_field("calib_success", 32'(e.calib_success), 32'(o_calib_success));
        check_field("last", 32'(e.last), 32'(o_last));
    endfunction

    // Observe both channels at each edge; predict before checking
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) deframe_word(i_is_message, i_word);
            if (o_valid && i_ready) check_result();
            if ((i_valid && o_ready) || (o_valid && i_ready)
                || (psel && penable && pwrite && pready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // End the run if no handshake completes for too long
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive receiver ready: changing stall patterns, or a long hold on request
    initial begin
        int mode;
        int mode_left;
        int tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= ($urandom_range(0, 99) >= 30);
                    2: i_ready <= ((tick % 7) < 4);
                    default: i_ready <= ($urandom_range(0, 99) >= 70);
                endcase
            end
        end
    end

    // Offer one word and hold it until accepted; gaps fall between bursts
    task automatic send_word(input logic msg, input logic [31:0] w);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap = (sender_steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid <= 1'b1;
        i_is_message <= msg;
        i_word <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (msg) words_sent++;
    endtask

    // Drop valid and hold until every expected result has come out
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_TEL_BEGIN: code_tel_begin = data;
            REG_TEL_END:   code_tel_end = data;
            REG_CAL_BEGIN: code_cal_begin = data;
            REG_CAL_END:   code_cal_end = data;
            default: ;
        endcase
        penable <= 1'b0;
    endtask

    // Write all four frame codes once the block is idle
    task automatic set_codes(input logic [31:0] tb, input logic [31:0] te,
                             input logic [31:0] cb, input logic [31:0] ce);
        wait_drained();
        apb_write(REG_TEL_BEGIN, tb);
        apb_write(REG_TEL_END, te);
        apb_write(REG_CAL_BEGIN, cb);
        apb_write(REG_CAL_END, ce);
        psel <= 1'b0;
        pwrite <= 1'b0;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 19))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Send the words in frame_words, damaged as asked
    task automatic send_frame(input t_frame_flaw flaw);
        int cut;
        cut = frame_words.size();
        if (flaw == FLAW_CUT) cut = $urandom_range(1, frame_words.size() - 1);
        if (flaw == FLAW_BAD_END) frame_words[frame_words.size() - 1] = $urandom;
        for (int i = 0; i < cut; i++) begin
            // slip in non-message events, some carrying a begin code
            if (flaw == FLAW_EVENTS && $urandom_range(0, 3) == 0)
                send_word(1'b0, $urandom_range(0, 1) ? code_tel_begin : $urandom);
            send_word(1'b1, frame_words[i]);
        end
    endtask

    task automatic send_telemetry(input logic [31:0] mask, input t_frame_flaw flaw);
        frame_words = {};
        frame_words.push_back(code_tel_begin);
        frame_words.push_back(mask);
        for (int i = 0; i < AXES + 3; i++) frame_words.push_back(pick_word());
        frame_words.push_back(code_tel_end);
        send_frame(flaw);
    endtask

    task automatic send_calibration(input logic [31:0] success, input t_frame_flaw flaw);
        frame_words = {};
        frame_words.push_back(code_cal_begin);
        frame_words.push_back(pick_word());
        frame_words.push_back(success);
        for (int i = 0; i < 3; i++) frame_words.push_back(pick_word());
        frame_words.push_back(code_cal_end);
        send_frame(flaw);
    endtask

    // Mixed frames, mostly clean, some damaged, some stray words
    task automatic run_traffic(input int n_words);
        int target;
        int pick;
        int r;
        t_frame_flaw flaw;
        target = words_sent + n_words;
        while (words_sent < target) begin
            pick = $urandom_range(0, 99);
            r = $urandom_range(0, 9);
            flaw = FLAW_NONE;
            if (r == 0) flaw = FLAW_BAD_END;
            else if (r == 1) flaw = FLAW_CUT;
            else if (r == 2) flaw = FLAW_EVENTS;
            if (pick < 45)
                send_telemetry($urandom_range(0, 1) ? ($urandom | POS_MASK) : $urandom, flaw);
            else if (pick < 85)
                send_calibration(($urandom_range(0, 2) == 0) ? 32'h0 : pick_word(), flaw);
            else
                send_word(1'($urandom_range(0, 1)), pick_word());
        end
    endtask

    // All codes zero after reset: a message word of zero always restarts a telemetry frame
    task automatic test_reset_defaults();
        send_word(1'b0, 32'h0000_0000);
        send_word(1'b1, 32'h1234_5678);
        send_word(1'b1, 32'h0000_0000);
        send_word(1'b1, 32'h0000_0007);
        send_word(1'b1, $urandom);
        send_word(1'b1, 32'h0000_0000);
    endtask

    // One clean frame of each type carrying extreme field values
    task automatic test_directed_frames();
        logic [31:0] edge_words [6];
        edge_words = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                       32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0001};
        set_codes(32'hA5A5_0001, 32'h5A5A_FFFE, 32'hC0DE_0002, 32'hC0DE_FFFD);
        frame_words = {};
        frame_words.push_back(code_tel_begin);
        frame_words.push_back(32'hFFFF_FFFF);
        for (int i = 0; i < AXES; i++) frame_words.push_back(edge_words[i % 6]);
        frame_words.push_back(32'h7FFF_FFFF);
        frame_words.push_back(32'h8000_0000);
        frame_words.push_back(32'h0000_0000);
        frame_words.push_back(code_tel_end);
        send_frame(FLAW_NONE);
        frame_words = {code_cal_begin, 32'hFFFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                       32'h7FFF_FFFF, 32'h8000_0000, code_cal_end};
        send_frame(FLAW_NONE);
    endtask

    // Same begin code for both types: telemetry takes it
    task automatic test_equal_begin_codes();
        logic [31:0] code;
        code = $urandom;
        set_codes(code, $urandom, code, $urandom);
        run_traffic(30);
    endtask

    // Telemetry end code equal to the calibration begin code
    task automatic test_end_matches_begin();
        logic [31:0] code;
        code = $urandom;
        set_codes($urandom, code, code, $urandom);
        run_traffic(30);
    endtask

    task automatic test_extreme_codes();
        set_codes(32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        sender_steady = 1'b1;
        run_traffic(40);
        sender_steady = 1'b0;
        set_codes(32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        run_traffic(40);
    endtask

    task automatic test_random_codes();
        for (int k = 0; k < 2; k++) begin
            set_codes($urandom, $urandom, $urandom, $urandom);
            run_traffic(30);
        end
    endtask

    // Hold the output off while frames keep coming, then drain
    task automatic test_output_backpressure();
        set_codes($urandom, $urandom, $urandom, $urandom);
        hold_req = 1'b1;
        for (int k = 0; k < 3; k++) begin
            send_telemetry($urandom | POS_MASK, FLAW_NONE);
            send_calibration($urandom, FLAW_NONE);
        end
        wait_drained();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_directed_frames();
        test_equal_begin_codes();
        test_end_matches_begin();
        test_extreme_codes();
        test_random_codes();
        test_output_backpressure();
        run_traffic(30);
        wait_drained();
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
